### rtl/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared types and codes for the aged, deduplicating message table.
// ----------------------------------------------------------------------------
package ttl_pkg;

  localparam int TableDepthDef = 16;
  localparam int MaxResults    = 16;
  localparam int QueueDepth    = 2;

  typedef enum logic [2:0] {
    FN_INSERT    = 3'd0,
    FN_INSERT_SN = 3'd1,
    FN_AGE       = 3'd2,
    FN_REMOVE    = 3'd3,
    FN_CLR_SEEN  = 3'd4,
    FN_LIST_ALL  = 3'd5,
    FN_LIST_UNSN = 3'd6,
    FN_COUNT     = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_LISTED  = 3'd3,
    ST_REMOVED = 3'd4,
    ST_NONE    = 3'd5,
    ST_COUNT   = 3'd6,
    ST_DONE    = 3'd7
  } status_t;

  // one queued request
  typedef struct packed {
    func_t       func;
    logic [31:0] src_ip;
    logic [7:0]  msg_id;
    logic [31:0] dst_ip;
    logic [7:0]  ttl;
    logic        seen_flag;
    logic [15:0] handle;
    logic [31:0] net_addr;
    logic [31:0] net_mask;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_LIST = 2'd1
  } bk_state_t;

endpackage

### rtl/ttl_front.sv
// ----------------------------------------------------------------------------
// ttl_front
// Accepts requests into a short queue and hands them to the back end.
// ----------------------------------------------------------------------------
module ttl_front
  import ttl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic avail,
  output req_t head
);

  localparam int PtrW = $clog2(QueueDepth);

  req_t              q [QueueDepth];
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW:0]     fill;

  assign full  = (fill == (PtrW+1)'(QueueDepth));
  assign avail = (fill != '0);
  assign head  = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_req;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (!push && pop) fill <= fill - 1'b1;
    end
  end

endmodule

### rtl/ttl_back.sv
// ----------------------------------------------------------------------------
// ttl_back
// Holds the record table and executes one queued request at a time.
// ----------------------------------------------------------------------------
module ttl_back
  import ttl_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  req_t        head,
  output logic        pop,
  output logic        strobe,
  output status_t     status,
  output logic [15:0] out_handle,
  output logic [31:0] out_src_ip,
  output logic [7:0]  out_msg_id,
  output logic [31:0] out_dst_ip,
  output logic [7:0]  out_ttl,
  output logic        out_seen,
  output logic [4:0]  entry_count,
  output logic        last,
  output logic        idle
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int LstW = $clog2(MaxResults + 1);

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [31:0] slot_src  [TABLE_DEPTH];
  logic [7:0]  slot_id   [TABLE_DEPTH];
  logic [31:0] slot_dst  [TABLE_DEPTH];
  logic [7:0]  slot_life [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_seen;
  logic [15:0] slot_ref  [TABLE_DEPTH];
  logic [CntW-1:0] held_count;

  bk_state_t state, state_next;
  logic            unseen_only;
  logic [39:0]     prev_key;
  logic            have_prev;
  logic [LstW-1:0] listed;
  logic [TABLE_DEPTH-1:0] scanned;

  // parallel key compare and free search
  logic [TABLE_DEPTH-1:0] hit, elig, later;
  logic [IdxW-1:0] hit_idx, free_idx, min_idx;
  logic            any_hit, any_free, any_min, any_min2;
  logic [39:0]     min_key;
  logic [CntW-1:0] elig_count;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      hit[i] = slot_valid[i] && slot_src[i] == head.src_ip && slot_id[i] == head.msg_id;
      if (hit[i]) begin
        hit_idx = IdxW'(i);
        any_hit = 1'b1;
      end
      if (!slot_valid[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  // candidates for the next listed record: above the previous key
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      elig[i]  = slot_valid[i] && !(unseen_only && slot_seen[i]);
      later[i] = elig[i] && (!have_prev || {slot_src[i], slot_id[i]} > prev_key);
    end
  end

  // number of records eligible for the listing
  assign elig_count = CntW'($countones(elig));

  // running minimum over stored keys, one entry per listing cycle
  logic [IdxW-1:0] scan_idx;
  logic            scan_done;
  always_comb begin
    scan_idx  = '0;
    scan_done = 1'b1;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!scanned[i]) begin
        scan_idx  = IdxW'(i);
        scan_done = 1'b0;
      end
    end
  end

  assign any_min2 = any_min;
  assign idle = (state == BK_IDLE) && !avail;

  logic [39:0] scan_key;
  assign scan_key = {slot_src[scan_idx], slot_id[scan_idx]};

  // sequencer
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: if (avail) begin
        pop = 1'b1;
        if (head.func == FN_LIST_ALL || head.func == FN_LIST_UNSN) state_next = BK_LIST;
      end
      BK_LIST: if (scan_done && (!any_min2 || listed == LstW'(MaxResults - 1)))
        state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // table update and result generation
  always_ff @(posedge clk) begin
    logic [CntW-1:0] cnt;
    logic [7:0]      life;
    logic            anyr;
    if (rst) begin
      slot_valid <= '0;
      held_count <= '0;
      strobe     <= 1'b0;
      scanned    <= '0;
      any_min    <= 1'b0;
    end else begin
      strobe      <= 1'b0;
      out_handle  <= '0;
      out_src_ip  <= '0;
      out_msg_id  <= '0;
      out_dst_ip  <= '0;
      out_ttl     <= '0;
      out_seen    <= 1'b0;
      last        <= 1'b1;
      cnt  = held_count;
      anyr = 1'b0;
      if (state == BK_IDLE && avail) begin
        strobe <= 1'b1;
        priority case (head.func)
          FN_INSERT, FN_INSERT_SN: begin
            if (any_hit) begin
              if (head.func == FN_INSERT_SN) slot_seen[hit_idx] <= 1'b1;
              status     <= ST_DUP;
              out_handle <= slot_ref[hit_idx];
              out_src_ip <= slot_src[hit_idx];
              out_msg_id <= slot_id[hit_idx];
              out_dst_ip <= slot_dst[hit_idx];
              out_ttl    <= slot_life[hit_idx];
              out_seen   <= slot_seen[hit_idx] | (head.func == FN_INSERT_SN);
            end else if (!any_free) begin
              status <= ST_FULL;
            end else begin
              slot_valid[free_idx] <= 1'b1;
              slot_src[free_idx]   <= head.src_ip;
              slot_id[free_idx]    <= head.msg_id;
              slot_dst[free_idx]   <= head.dst_ip;
              slot_life[free_idx]  <= head.ttl;
              slot_seen[free_idx]  <= head.seen_flag | (head.func == FN_INSERT_SN);
              slot_ref[free_idx]   <= head.handle;
              cnt = cnt + 1'b1;
              status     <= ST_NEW;
              out_handle <= head.handle;
              out_src_ip <= head.src_ip;
              out_msg_id <= head.msg_id;
              out_dst_ip <= head.dst_ip;
              out_ttl    <= head.ttl;
              out_seen   <= head.seen_flag | (head.func == FN_INSERT_SN);
            end
          end
          FN_AGE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (slot_valid[i]) begin
                life = slot_life[i] - 8'd1;
                slot_life[i] <= life;
                if (life == 8'd0) begin
                  slot_valid[i] <= 1'b0;
                  cnt = cnt - 1'b1;
                end
              end
            end
            status <= ST_DONE;
          end
          FN_REMOVE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (slot_valid[i] &&
                  (slot_dst[i] & head.net_mask) == (head.net_addr & head.net_mask)) begin
                slot_valid[i] <= 1'b0;
                cnt  = cnt - 1'b1;
                anyr = 1'b1;
              end
            end
            status <= anyr ? ST_REMOVED : ST_NONE;
          end
          FN_CLR_SEEN: begin
            slot_seen <= '0;
            status    <= ST_DONE;
          end
          FN_LIST_ALL, FN_LIST_UNSN: begin
            // listing is carried out over the following cycles
            strobe      <= 1'b0;
            unseen_only <= (head.func == FN_LIST_UNSN);
            have_prev   <= 1'b0;
            listed      <= '0;
            scanned     <= '0;
            any_min     <= 1'b0;
          end
          default: status <= ST_COUNT;
        endcase
        entry_count <= 5'(cnt);
        held_count  <= cnt;
      end else if (state == BK_LIST) begin
        entry_count <= 5'(held_count);
        if (!scan_done) begin
          // fold one entry into the running minimum
          scanned[scan_idx] <= 1'b1;
          if (later[scan_idx] && (!any_min || scan_key < min_key)) begin
            min_idx <= scan_idx;
            min_key <= scan_key;
            any_min <= 1'b1;
          end
        end else begin
          strobe <= 1'b1;
          if (!any_min) begin
            status <= ST_NONE;
          end else begin
            status     <= ST_LISTED;
            out_handle <= slot_ref[min_idx];
            out_src_ip <= slot_src[min_idx];
            out_msg_id <= slot_id[min_idx];
            out_dst_ip <= slot_dst[min_idx];
            out_ttl    <= slot_life[min_idx];
            out_seen   <= slot_seen[min_idx];
            // final record: all eligible ones reported or the result cap reached
            last       <= (listed == LstW'(MaxResults - 1)) ||
                          (int'(listed) + 1 == int'(elig_count));
            prev_key  <= min_key;
            have_prev <= 1'b1;
            listed    <= listed + 1'b1;
            scanned   <= '0;
            any_min   <= 1'b0;
          end
          // the empty scan after the final record closes the command silently
          if (!any_min && have_prev) strobe <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/ttl_aged_dedup_message_table.sv
// Non-listing commands pass through the request queue, then the result registers.
// Listing: each record comes from a sequential minimum scan of the table, and unless
// the result cap is reached, a trailing scan with no record closes it silently.
// Throughput: one request per cycle outside listing; a 2-entry queue absorbs bursts.
// Reset: synchronous, clears the table valid bits, count and queue.
// The receiver cannot stall: each result shows for one cycle under done.
// ----------------------------------------------------------------------------
// ttl_aged_dedup_message_table
// Message table with key dedup, TTL aging, network removal and sorted listing.
// ----------------------------------------------------------------------------
module ttl_aged_dedup_message_table
  import ttl_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] src_ip,
  input  logic [7:0]  msg_id,
  input  logic [31:0] dst_ip,
  input  logic [7:0]  ttl,
  input  logic        seen_flag,
  input  logic [15:0] handle,
  input  logic [31:0] net_addr,
  input  logic [31:0] net_mask,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] out_handle,
  output logic [31:0] out_src_ip,
  output logic [7:0]  out_msg_id,
  output logic [31:0] out_dst_ip,
  output logic [7:0]  out_ttl,
  output logic        out_seen,
  output logic [4:0]  entry_count,
  output logic        last
);

  req_t    in_req, head;
  logic    q_full, avail, pop, push, idle;
  status_t st;

  assign in_req = '{func: func_t'(func), src_ip: src_ip, msg_id: msg_id, dst_ip: dst_ip,
                    ttl: ttl, seen_flag: seen_flag, handle: handle,
                    net_addr: net_addr, net_mask: net_mask};
  assign busy   = q_full;
  assign push   = start && !busy;
  assign status = st;

  // request queue
  ttl_front u_front (
    .clk(clk), .rst(rst), .push(push), .push_req(in_req), .full(q_full),
    .pop(pop), .avail(avail), .head(head)
  );

  // table and executor
  ttl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .pop(pop),
    .strobe(done), .status(st), .out_handle(out_handle), .out_src_ip(out_src_ip),
    .out_msg_id(out_msg_id), .out_dst_ip(out_dst_ip), .out_ttl(out_ttl),
    .out_seen(out_seen), .entry_count(entry_count), .last(last), .idle(idle)
  );

  // no accept while the queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("push into full queue");

  // a request is only pulled from a non-empty queue
  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail) else $error("pop from empty queue");

  // idle back end produces no result next cycle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    idle && !start |=> !done) else $error("result without request");

endmodule

### bench/tb_ttl_aged_dedup_message_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ttl_aged_dedup_message_table
// Drives commands into the message table and checks every result against a
// behavioral table model: dedup, aging, network removal, seen clearing, listing and count.
// ----------------------------------------------------------------------------

// expected results of the message table, updated per accepted request
class msg_table_scoreboard;
  localparam int Depth = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hnd;
    logic [31:0] src;
    logic [7:0]  id;
    logic [31:0] dst;
    logic [7:0]  life;
    logic        seen;
    logic [4:0]  cnt;
    logic        last;
  } result_t;

  bit          valid [Depth];
  logic [31:0] src [Depth];
  logic [7:0]  id [Depth];
  logic [31:0] dst [Depth];
  logic [7:0]  life [Depth];
  logic        seen [Depth];
  logic [15:0] hnd [Depth];
  int          held;
  result_t     pending [$];
  int          errors;
  int          checked;

  function new();
    foreach (valid[i]) valid[i] = 0;
    held = 0;
    errors = 0;
    checked = 0;
  endfunction

  // append one expected result
  function void add_expect(result_t r);
    pending.insert(pending.size(), r);
  endfunction

  function result_t plain(logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.cnt = held[4:0];
    r.last = 1'b1;
    return r;
  endfunction

  function result_t rec(logic [2:0] st, int i);
    result_t r;
    r = plain(st);
    r.hnd = hnd[i];
    r.src = src[i];
    r.id = id[i];
    r.dst = dst[i];
    r.life = life[i];
    r.seen = seen[i];
    return r;
  endfunction

  // apply one accepted request and queue its results
  function void note_request(ttl_pkg::req_t q);
    int fr;
    int order [$];
    bit hit;
    result_t r;
    fr = -1;
    hit = 0;
    case (q.func)
      ttl_pkg::FN_INSERT, ttl_pkg::FN_INSERT_SN: begin
        for (int i = 0; i < Depth && !hit; i++) begin
          if (valid[i] && src[i] == q.src_ip && id[i] == q.msg_id) begin
            if (q.func == ttl_pkg::FN_INSERT_SN) seen[i] = 1'b1;
            add_expect(rec(ttl_pkg::ST_DUP, i));
            hit = 1;
          end else if (!valid[i] && fr < 0) fr = i;
        end
        if (!hit) begin
          if (fr < 0) add_expect(plain(ttl_pkg::ST_FULL));
          else begin
            valid[fr] = 1;
            src[fr] = q.src_ip;
            id[fr] = q.msg_id;
            dst[fr] = q.dst_ip;
            life[fr] = q.ttl;
            seen[fr] = (q.func == ttl_pkg::FN_INSERT_SN) ? 1'b1 : q.seen_flag;
            hnd[fr] = q.handle;
            held++;
            add_expect(rec(ttl_pkg::ST_NEW, fr));
          end
        end
      end
      ttl_pkg::FN_AGE: begin
        for (int i = 0; i < Depth; i++) begin
          if (valid[i]) begin
            life[i] = life[i] - 8'd1;
            if (life[i] == 0) begin valid[i] = 0; held--; end
          end
        end
        add_expect(plain(ttl_pkg::ST_DONE));
      end
      ttl_pkg::FN_REMOVE: begin
        for (int i = 0; i < Depth; i++) begin
          if (valid[i] && (dst[i] & q.net_mask) == (q.net_addr & q.net_mask)) begin
            valid[i] = 0;
            held--;
            hit = 1;
          end
        end
        add_expect(plain(hit ? ttl_pkg::ST_REMOVED : ttl_pkg::ST_NONE));
      end
      ttl_pkg::FN_CLR_SEEN: begin
        for (int i = 0; i < Depth; i++) if (valid[i]) seen[i] = 1'b0;
        add_expect(plain(ttl_pkg::ST_DONE));
      end
      ttl_pkg::FN_LIST_ALL, ttl_pkg::FN_LIST_UNSN: begin
        // insertion sort on {src, id}
        for (int i = 0; i < Depth; i++) begin
          int j;
          j = 0;
          if (valid[i] && !(q.func == ttl_pkg::FN_LIST_UNSN && seen[i])) begin
            while (j < order.size() && {src[order[j]], id[order[j]]} < {src[i], id[i]})
              j++;
            order.insert(j, i);
          end
        end
        if (order.size() == 0) add_expect(plain(ttl_pkg::ST_NONE));
        foreach (order[k]) begin
          r = rec(ttl_pkg::ST_LISTED, order[k]);
          r.last = (k == order.size() - 1);
          add_expect(r);
        end
      end
      default: add_expect(plain(ttl_pkg::ST_COUNT));
    endcase
  endfunction

  // compare one result with the oldest expectation
  function void check_result(result_t got);
    result_t exp;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: exp st=%0d h=%h s=%h id=%h d=%h t=%h sn=%b c=%0d l=%b",
                 exp.status, exp.hnd, exp.src, exp.id, exp.dst, exp.life, exp.seen,
                 exp.cnt, exp.last);
        $display("          got st=%0d h=%h s=%h id=%h d=%h t=%h sn=%b c=%0d l=%b",
                 got.status, got.hnd, got.src, got.id, got.dst, got.life, got.seen,
                 got.cnt, got.last);
      end
    end
  endfunction
endclass

module tb_ttl_aged_dedup_message_table;
  import ttl_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  func;
  logic [31:0] src_ip;
  logic [7:0]  msg_id;
  logic [31:0] dst_ip;
  logic [7:0]  ttl;
  logic        seen_flag;
  logic [15:0] handle;
  logic [31:0] net_addr;
  logic [31:0] net_mask;
  logic        done;
  logic [2:0]  status;
  logic [15:0] out_handle;
  logic [31:0] out_src_ip;
  logic [7:0]  out_msg_id;
  logic [31:0] out_dst_ip;
  logic [7:0]  out_ttl;
  logic        out_seen;
  logic [4:0]  entry_count;
  logic        last;

  msg_table_scoreboard table_sb;
  int cycles;
  int sent;
  int burst_left;
  int listings;

  ttl_aged_dedup_message_table u_top (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // result sampling and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done)
      table_sb.check_result({status, out_handle, out_src_ip, out_msg_id, out_dst_ip,
                             out_ttl, out_seen, entry_count, last});
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_ttl_aged_dedup_message_table NOT OK");
      $finish;
    end
  end

  // small key space so duplicates and sorting are exercised
  function automatic req_t rand_req(bit well_formed);
    req_t q;
    int pick;
    q.src_ip = $urandom_range(0, 3) == 0 ? $urandom : {30'h0, 2'($urandom_range(0, 3))};
    q.msg_id = 8'($urandom_range(0, 5));
    if ($urandom_range(0, 7) == 0) q.msg_id = 8'($urandom);
    q.dst_ip = {$urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd10, 24'($urandom)};
    q.ttl = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 4));
    q.seen_flag = 1'($urandom);
    q.handle = 16'($urandom);
    q.net_addr = {8'd10, 8'($urandom_range(0, 255)), 16'($urandom)};
    q.net_mask = $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_0000 << $urandom_range(0, 8);
    pick = $urandom_range(0, 99);
    if (!well_formed) q.func = func_t'($urandom_range(0, 7));
    else if (pick < 55) q.func = pick < 40 ? FN_INSERT : FN_INSERT_SN;
    else if (pick < 65) q.func = FN_AGE;
    else if (pick < 72) q.func = FN_REMOVE;
    else if (pick < 77) q.func = FN_CLR_SEEN;
    else if (pick < 87) q.func = FN_LIST_ALL;
    else if (pick < 94) q.func = FN_LIST_UNSN;
    else q.func = FN_COUNT;
    return q;
  endfunction

  // hold a request until accepted, with bursty gaps between requests
  task automatic send_request(req_t q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    func <= q.func;
    src_ip <= q.src_ip;
    msg_id <= q.msg_id;
    dst_ip <= q.dst_ip;
    ttl <= q.ttl;
    seen_flag <= q.seen_flag;
    handle <= q.handle;
    net_addr <= q.net_addr;
    net_mask <= q.net_mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_sb.note_request(q);
    sent++;
    if (q.func == FN_LIST_ALL || q.func == FN_LIST_UNSN) listings++;
    @(negedge clk);
  endtask

  task automatic send_fields(func_t f, logic [31:0] s, logic [7:0] i, logic [31:0] d,
                             logic [7:0] t, logic sn, logic [15:0] h,
                             logic [31:0] na, logic [31:0] nm);
    req_t q;
    q = '{f, s, i, d, t, sn, h, na, nm};
    send_request(q);
  endtask

  initial begin
    req_t q;
    table_sb = new();
    cycles = 0;
    sent = 0;
    burst_left = 0;
    listings = 0;
    rst = 1'b1;
    start = 1'b0;
    {func, src_ip, msg_id, dst_ip, ttl, seen_flag, handle, net_addr, net_mask} = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table, extremes, duplicates, fill to full, wraps
    send_fields(FN_LIST_ALL, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_COUNT, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_INSERT, '1, '1, '1, '1, 1'b1, '1, '0, '0);
    send_fields(FN_INSERT, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_INSERT, '0, '0, 32'h1234, 8'd9, 1'b1, 16'h5555, '0, '0);
    send_fields(FN_INSERT_SN, '1, '1, '0, 8'd3, 1'b0, 16'h1, '0, '0);
    send_fields(FN_INSERT_SN, 32'h8000_0000, 8'h80, 32'hAAAA_AAAA, 8'd1, 1'b0, 16'h8000,
                '0, '0);
    for (int k = 0; k < 14; k++)
      send_fields(FN_INSERT, 32'h100 - k, k[7:0], {8'd10, 24'(k)}, 8'(k + 2), k[0],
                  16'(k), '0, '0);
    send_fields(FN_LIST_UNSN, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_AGE, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_CLR_SEEN, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_LIST_ALL, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_REMOVE, '0, '0, '0, '0, 1'b0, '0, 32'h0A00_0000, 32'hFF00_0000);
    send_fields(FN_REMOVE, '0, '0, '0, '0, 1'b0, '0, 32'h5A5A_5A5A, '1);
    send_fields(FN_REMOVE, '0, '0, '0, '0, 1'b0, '0, '0, '0);
    send_fields(FN_LIST_UNSN, '0, '0, '0, '0, 1'b0, '0, '0, '0);

    // random: mostly well-formed traffic, some fully random commands
    for (int n = 0; n < 80; n++) begin
      q = rand_req($urandom_range(0, 9) != 0);
      send_request(q);
    end
    start <= 1'b0;

    while (table_sb.pending.size() != 0 && cycles < CycleLimit) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d requests sent (%0d listings), %0d results checked, %0d errors",
             sent, listings, table_sb.checked, table_sb.errors);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0)
      $display("tb_ttl_aged_dedup_message_table OK");
    else
      $display("tb_ttl_aged_dedup_message_table NOT OK");
    $finish;
  end
endmodule

### ttl_aged_dedup_message_table.f
rtl/ttl_pkg.sv
rtl/ttl_front.sv
rtl/ttl_back.sv
rtl/ttl_aged_dedup_message_table.sv
bench/tb_ttl_aged_dedup_message_table.sv
